/* hdl/trial_division_prime_factorizer_assert.svh */
// Assertion macros for the trial division prime factoriser.
// Included by the checker; needs no other file.
`ifndef TRIAL_DIVISION_PRIME_FACTORIZER_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_FACTORIZER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define TDPF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdpf assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define TDPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdpf assertion failed");

`endif

/* hdl/tdpf_pkg.sv */
// Shared constants for the trial division prime factoriser.
// No dependencies; used by the divider, the top level and the checker.
`timescale 1ns / 1ps

package tdpf_pkg;

  localparam int unsigned VALUE_W               = 32;
  localparam int unsigned CNT_W                 = $clog2(VALUE_W);
  localparam int unsigned DIVISOR_LIMIT_DEFAULT = 65536;

  // Factor word reported for the sign of a negative input.
  localparam logic [VALUE_W-1:0] SIGN_FACTOR = {VALUE_W{1'b1}};

endpackage

/* hdl/tdpf_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tdpf_pkg.
`timescale 1ns / 1ps

module tdpf_div #(
  parameter int unsigned DIV_W = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tdpf_pkg::VALUE_W-1:0] dividend,
  input  logic [DIV_W-1:0]            divisor,
  output logic                        done,
  output logic [tdpf_pkg::VALUE_W-1:0] quotient,
  output logic [DIV_W-1:0]            remainder
);
  import tdpf_pkg::*;

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] work;
  logic [DIV_W-1:0]   part;
  logic [DIV_W-1:0]   dsr;
  logic [DIV_W:0]     shifted;
  logic [DIV_W:0]     diff;
  logic               fits;

  assign shifted = {part, work[VALUE_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(VALUE_W - 1);
        work    <= dividend;
        part    <= '0;
        dsr     <= divisor;
      end else if (running) begin
        work <= {work[VALUE_W-2:0], fits};
        part <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = work;
  assign remainder = part;

endmodule

/* hdl/trial_division_prime_factorizer.sv */
// Top level of the trial division prime factoriser: sequencer and output word register.
// Depends on tdpf_pkg and tdpf_div.
`timescale 1ns / 1ps

// Usage
//   Input channel: value (signed 32-bit) with value_valid / value_ready.
//   Output channel: factor (signed 32-bit) and last with factor_valid / factor_ready.
//   One input word yields one to 32 output words: -1 first for a negative
//   input, then the prime factors in nondecreasing order, the remaining
//   cofactor last. Zero yields a single 0, magnitude one yields 1.
//   The final word of each input carries last = 1.
// Timing
//   value_ready is high only while the sequencer is idle; it drops for the
//   whole factorisation. Each trial divisor (2, then odd numbers) costs one
//   pass of the shared restoring divider plus sequencing. A prime near 2^31
//   needs about 23200 trials. The divider passes set the rate.
// Reset and stalls
//   rst (synchronous, active high) returns the sequencer to idle and empties
//   the output register. A stalled receiver holds the current word; the
//   sequencer waits until the register is free before placing the next one.
//   The next input may be taken while the final word still waits.

module trial_division_prime_factorizer #(
  parameter int unsigned DIVISOR_LIMIT = tdpf_pkg::DIVISOR_LIMIT_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [tdpf_pkg::VALUE_W-1:0] value,
  input  logic                               value_valid,
  output logic                               value_ready,
  output logic signed [tdpf_pkg::VALUE_W-1:0] factor,
  output logic                               last,
  output logic                               factor_valid,
  input  logic                               factor_ready
);
  import tdpf_pkg::*;

  // Divisor wide enough to step past the limit by one odd increment.
  localparam int unsigned     DIV_W     = $clog2(DIVISOR_LIMIT + 3);
  localparam logic [DIV_W-1:0] LIMIT    = DIV_W'(DIVISOR_LIMIT);
  localparam logic [DIV_W-1:0] FIRST_DV = DIV_W'(2);
  localparam logic [DIV_W-1:0] FIRST_OD = DIV_W'(3);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,  // wait for an input word
    S_SIGN = 6'b000010,  // zero and sign words
    S_DIV  = 6'b000100,  // check the bound, launch a trial division
    S_WAIT = 6'b001000,  // wait for the divider
    S_PUSH = 6'b010000,  // place a found factor
    S_COF  = 6'b100000   // place the cofactor as the final word
  } state_t;

  state_t             state, state_next;
  logic [VALUE_W-1:0] mag, mag_next;
  logic [DIV_W-1:0]   dv, dv_next;
  logic               neg, neg_next;
  logic [VALUE_W-1:0] value_u;

  logic               push;
  logic [VALUE_W-1:0] push_factor;
  logic               push_last;
  logic               slot_free;

  logic               div_start;
  logic               div_done;
  logic [VALUE_W-1:0] div_q;
  logic [DIV_W-1:0]   div_r;
  state_t             after_sign;

  tdpf_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (dv),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign value_u     = value;
  assign value_ready = (state == S_IDLE);
  // The output register can take a word when empty or being emptied.
  assign slot_free   = !factor_valid || factor_ready;
  assign after_sign  = (mag == VALUE_W'(1)) ? S_COF : S_DIV;

  always_comb begin
    state_next  = state;
    mag_next    = mag;
    dv_next     = dv;
    neg_next    = neg;
    push        = 1'b0;
    push_factor = '0;
    push_last   = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (value_valid) begin
          // Take the magnitude; the most negative value wraps to 2^31 unsigned.
          neg_next   = value_u[VALUE_W-1];
          mag_next   = value_u[VALUE_W-1] ? ('0 - value_u) : value_u;
          dv_next    = FIRST_DV;
          state_next = S_SIGN;
        end
      end
      S_SIGN: begin
        if (mag == '0) begin
          if (slot_free) begin
            push       = 1'b1;
            push_last  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (neg) begin
          if (slot_free) begin
            push        = 1'b1;
            push_factor = SIGN_FACTOR;
            state_next  = after_sign;
          end
        end else begin
          state_next = after_sign;
        end
      end
      S_DIV: begin
        if (dv > LIMIT) begin
          state_next = S_COF;
        end else begin
          div_start  = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (div_done) begin
          // A quotient below the divisor means divisor^2 exceeds the cofactor.
          if (div_q < VALUE_W'(dv)) begin
            state_next = S_COF;
          end else if (div_r == '0) begin
            mag_next   = div_q;
            state_next = S_PUSH;
          end else begin
            dv_next    = (dv == FIRST_DV) ? FIRST_OD : dv + DIV_W'(2);
            state_next = S_DIV;
          end
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          push        = 1'b1;
          push_factor = VALUE_W'(dv);
          state_next  = S_DIV;
        end
      end
      S_COF: begin
        if (slot_free) begin
          push        = 1'b1;
          push_factor = mag;
          push_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    mag <= mag_next;
    dv  <= dv_next;
    neg <= neg_next;
  end

  // Output word register: load on push, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      factor_valid <= 1'b0;
    end else if (push) begin
      factor_valid <= 1'b1;
    end else if (factor_ready) begin
      factor_valid <= 1'b0;
    end
    if (push) begin
      factor <= push_factor;
      last   <= push_last;
    end
  end

endmodule

/* hdl/tdpf_checker.sv */
// Port-level checker for the trial division prime factoriser, bound to the top level.
// Depends on tdpf_pkg and trial_division_prime_factorizer_assert.svh.
`timescale 1ns / 1ps

`include "trial_division_prime_factorizer_assert.svh"

module tdpf_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               value_valid,
  input logic                               value_ready,
  input logic signed [tdpf_pkg::VALUE_W-1:0] factor,
  input logic                               last,
  input logic                               factor_valid,
  input logic                               factor_ready
);
  import tdpf_pkg::*;

  // Drop ready once a word is taken: one input at a time.
  `TDPF_ASSERT_NEXT(a_busy_after_accept, clk, rst, value_valid && value_ready, !value_ready)
  // Hold a stalled output word.
  `TDPF_ASSERT_NEXT(a_out_hold, clk, rst, factor_valid && !factor_ready, factor_valid && $stable(factor) && $stable(last))
  // The sign word never ends an input.
  `TDPF_ASSERT_SAME(a_sign_not_last, clk, rst, factor_valid && factor == -1, !last)
  // A zero word always ends its input.
  `TDPF_ASSERT_SAME(a_zero_is_last, clk, rst, factor_valid && factor == 0, last)

endmodule

bind trial_division_prime_factorizer tdpf_checker u_tdpf_checker (
  .clk          (clk),
  .rst          (rst),
  .value_valid  (value_valid),
  .value_ready  (value_ready),
  .factor       (factor),
  .last         (last),
  .factor_valid (factor_valid),
  .factor_ready (factor_ready)
);
